FILE: hw/rtl/bmf_pkg.sv
// bmf_pkg.sv: shared constants, divisor code and result tag of the 3x3 box mean filter
// no dependencies; used by every file under hw/rtl
package bmf_pkg;

   localparam int MAX_DIM_DEFAULT      = 1024;
   localparam int CHANNEL_BITS_DEFAULT = 16;
   localparam int NUM_CHANNELS         = 3;
   localparam int DIM_BITS             = 11;
   localparam int DIM_RESET            = 1024;
   localparam int OUT_POS_BITS         = 10;

   // neighbor count of one output pixel: corner, edge, interior
   typedef enum logic [1:0] {
      DIV_BY_4,
      DIV_BY_6,
      DIV_BY_9
   } div_code_type;

   typedef struct packed {
      logic [OUT_POS_BITS-1:0] row;
      logic [OUT_POS_BITS-1:0] col;
      logic                    last;
      logic                    done;
      div_code_type            div_code;
   } result_tag_type;

endpackage

FILE: hw/rtl/box_mean_filter_3x3.sv
// box_mean_filter_3x3.sv: 3x3 box mean over a square rgb image streamed in raster order
// depends on bmf_pkg, bmf_line_ram and bmf_mean_div
// results are registered in stages 1 to 3, then in the divider's quotient and output registers
// throughput: one request per cycle while the output is ready; a two-result request (last column
// below row 0, bottom row past column 0) or the bottom-right one holds the input while stage 2 emits
// reset: synchronous, clears valids, position and side (1024, or MAX_DIM if smaller); line stores are not cleared
module box_mean_filter_3x3
   import bmf_pkg::*;
#(
   parameter int  MAX_DIM      = MAX_DIM_DEFAULT,
   parameter int  CHANNEL_BITS = CHANNEL_BITS_DEFAULT,
   localparam int REQ_BITS     = ((NUM_CHANNELS * CHANNEL_BITS + 7) / 8) * 8,
   localparam int RSP_BITS     = ((NUM_CHANNELS * CHANNEL_BITS + 2 * OUT_POS_BITS + 7) / 8) * 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [DIM_BITS-1:0] csr_wdata,   // image_dim
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [REQ_BITS-1:0] req_tdata,   // red_in, green_in, blue_in from bit 0 up, zero pad
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RSP_BITS-1:0] rsp_tdata,   // red_out, green_out, blue_out, out_row, out_col
   output logic                rsp_tlast,   // last_of_run
   output logic                rsp_tuser    // frame_done
);

   localparam int POS_BITS   = $clog2(MAX_DIM);
   localparam int PIX_BITS   = NUM_CHANNELS * CHANNEL_BITS;
   localparam int S2_BITS    = CHANNEL_BITS + 1;
   localparam int S3_BITS    = CHANNEL_BITS + 2;
   localparam int SUM_BITS   = CHANNEL_BITS + 4;
   localparam int WIN_COLS   = 3;
   localparam int NUM_SLOTS  = 4;
   localparam int RESET_SIDE = (DIM_RESET > MAX_DIM) ? MAX_DIM : DIM_RESET;
   localparam logic [POS_BITS-1:0] RESET_LAST = POS_BITS'(RESET_SIDE - 1);

   // result slots of one request at row r, column c, in delivery order
   localparam int SLOT_UP_LEFT   = 0;   // (r-1, c-1)
   localparam int SLOT_UP_HERE   = 1;   // (r-1, c) at the last column
   localparam int SLOT_LOW_LEFT  = 2;   // (r, c-1) on the last row
   localparam int SLOT_LOW_HERE  = 3;   // (r, c) bottom-right

   // side register and input position
   logic [POS_BITS-1:0]  side_last_ff;
   logic [POS_BITS-1:0]  side_last_in;
   logic [POS_BITS-1:0]  row_ff;
   logic [POS_BITS-1:0]  col_ff;
   logic                 at_last_col;
   logic                 at_last_row;
   logic                 req_fire;
   logic [PIX_BITS-1:0]  req_pixel;
   logic [PIX_BITS-1:0]  line_rd [2];

   // stage 1: request plus line store read data
   logic                 p1_ready;
   logic                 p1_valid_ff;
   logic [PIX_BITS-1:0]  p1_pixel_ff;
   logic [POS_BITS-1:0]  p1_row_ff;
   logic [POS_BITS-1:0]  p1_col_ff;
   logic                 p1_parity_ff;
   logic                 p1_last_col_ff;
   logic                 p1_last_row_ff;
   logic [PIX_BITS-1:0]  prev_pix;
   logic [PIX_BITS-1:0]  old_pix;
   logic [S2_BITS-1:0]   s2_in [NUM_CHANNELS];
   logic [S3_BITS-1:0]   s3_in [NUM_CHANNELS];
   logic [NUM_SLOTS-1:0] pend_in;

   // stage 2: column window and result sequencing
   logic                 p2_load;
   logic                 p2_ready;
   logic [S2_BITS-1:0]   win_s2_ff [WIN_COLS][NUM_CHANNELS];
   logic [S3_BITS-1:0]   win_s3_ff [WIN_COLS][NUM_CHANNELS];
   logic [POS_BITS-1:0]  p2_row_ff;
   logic [POS_BITS-1:0]  p2_col_ff;
   logic                 p2_top_ff;
   logic                 p2_left_ff;
   logic [NUM_SLOTS-1:0] pend_ff;
   logic                 pend_one;
   logic                 emit;
   logic [NUM_SLOTS-1:0] sel;
   logic                 row_lower;
   logic                 col_right;
   logic                 use_s3;
   logic                 three_cols;
   logic [POS_BITS-1:0]  row_m1;
   logic [POS_BITS-1:0]  col_m1;
   logic [S3_BITS-1:0]   col_val [WIN_COLS][NUM_CHANNELS];
   logic [SUM_BITS-1:0]  sum_in [NUM_CHANNELS];
   result_tag_type       tag_in;

   // stage 3: neighborhood sums into the divider
   logic                 p3_ready;
   logic                 p3_valid_ff;
   logic [SUM_BITS-1:0]  sum_ff [NUM_CHANNELS];
   result_tag_type       tag_ff;
   logic                 div_in_ready;
   logic [CHANNEL_BITS-1:0] mean [NUM_CHANNELS];
   result_tag_type       rsp_tag;

   // ------------------------------------------------------------------
   // side length: clamped to [2, MAX_DIM] when written, held as side - 1
   // ------------------------------------------------------------------
   always_comb begin
      priority if (32'(csr_wdata) < 32'd2) begin
         side_last_in = POS_BITS'(1);
      end else if (32'(csr_wdata) > 32'(MAX_DIM)) begin
         side_last_in = POS_BITS'(MAX_DIM - 1);
      end else begin
         side_last_in = POS_BITS'(32'(csr_wdata) - 32'd1);
      end
   end

   assign req_fire    = req_tvalid && req_tready;
   assign req_pixel   = req_tdata[PIX_BITS-1:0];
   assign at_last_col = (col_ff == side_last_ff);
   assign at_last_row = (row_ff == side_last_ff);

   // a side write restarts the frame; the bottom-right pixel wraps to (0,0)
   always_ff @(posedge clock) begin
      if (reset) begin
         side_last_ff <= RESET_LAST;
         row_ff       <= '0;
         col_ff       <= '0;
      end else if (csr_we) begin
         side_last_ff <= side_last_in;
         row_ff       <= '0;
         col_ff       <= '0;
      end else if (req_fire) begin
         if (at_last_col) begin
            col_ff <= '0;
            row_ff <= at_last_row ? '0 : row_ff + POS_BITS'(1);
         end else begin
            col_ff <= col_ff + POS_BITS'(1);
         end
      end
   end

   // ------------------------------------------------------------------
   // line stores: ping-pong by row parity; the store of this parity holds
   // row r-2 and is overwritten by row r at the same column (read-first)
   // ------------------------------------------------------------------
   for (genvar k = 0; k < 2; k++) begin : g_line
      bmf_line_ram #(
         .DEPTH (MAX_DIM),
         .WIDTH (PIX_BITS)
      ) u_line (
         .clock   (clock),
         .wr_en   (req_fire && (row_ff[0] == 1'(k))),
         .wr_addr (col_ff),
         .wr_data (req_pixel),
         .rd_en   (req_fire),
         .rd_addr (col_ff),
         .rd_data (line_rd[k])
      );
   end

   // ------------------------------------------------------------------
   // stage 1: vertical sums of the new column
   // ------------------------------------------------------------------
   assign p1_ready   = !p1_valid_ff || p2_ready;
   assign req_tready = p1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (p1_ready) begin
         p1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         p1_pixel_ff    <= req_pixel;
         p1_row_ff      <= row_ff;
         p1_col_ff      <= col_ff;
         p1_parity_ff   <= row_ff[0];
         p1_last_col_ff <= at_last_col;
         p1_last_row_ff <= at_last_row;
      end
   end

   always_comb begin
      prev_pix = p1_parity_ff ? line_rd[0] : line_rd[1];
      old_pix  = p1_parity_ff ? line_rd[1] : line_rd[0];
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
         // rows r-1..r, and rows r-2..r
         s2_in[ch] = S2_BITS'(p1_pixel_ff[ch*CHANNEL_BITS +: CHANNEL_BITS])
                   + S2_BITS'(prev_pix[ch*CHANNEL_BITS +: CHANNEL_BITS]);
         s3_in[ch] = S3_BITS'(s2_in[ch])
                   + S3_BITS'(old_pix[ch*CHANNEL_BITS +: CHANNEL_BITS]);
      end
      pend_in[SLOT_UP_LEFT]  = (p1_row_ff != '0) && (p1_col_ff != '0);
      pend_in[SLOT_UP_HERE]  = (p1_row_ff != '0) && p1_last_col_ff;
      pend_in[SLOT_LOW_LEFT] = p1_last_row_ff && (p1_col_ff != '0);
      pend_in[SLOT_LOW_HERE] = p1_last_row_ff && p1_last_col_ff;
   end

   // ------------------------------------------------------------------
   // stage 2: window of the last three columns; while stage 3 is ready, one result per cycle
   // ------------------------------------------------------------------
   assign pend_one = ((pend_ff & (pend_ff - NUM_SLOTS'(1))) == '0);
   assign p2_ready = (pend_ff == '0) || (p3_ready && pend_one);
   assign p2_load  = p1_valid_ff && p2_ready;
   assign emit     = (pend_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else if (p2_load) begin
         pend_ff <= pend_in;
      end else if (emit && p3_ready) begin
         pend_ff <= pend_ff & ~sel;
      end
   end

   always_ff @(posedge clock) begin
      if (p2_load) begin
         for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            win_s2_ff[0][ch] <= s2_in[ch];
            win_s3_ff[0][ch] <= s3_in[ch];
            for (int w = 1; w < WIN_COLS; w++) begin
               win_s2_ff[w][ch] <= win_s2_ff[w-1][ch];
               win_s3_ff[w][ch] <= win_s3_ff[w-1][ch];
            end
         end
         p2_row_ff  <= p1_row_ff;
         p2_col_ff  <= p1_col_ff;
         p2_top_ff  <= (p1_row_ff == POS_BITS'(1));
         p2_left_ff <= (p1_col_ff == POS_BITS'(1));
      end
   end

   // lowest pending slot goes first
   always_comb begin
      sel = '0;
      priority if (pend_ff[SLOT_UP_LEFT]) begin
         sel[SLOT_UP_LEFT] = 1'b1;
      end else if (pend_ff[SLOT_UP_HERE]) begin
         sel[SLOT_UP_HERE] = 1'b1;
      end else if (pend_ff[SLOT_LOW_LEFT]) begin
         sel[SLOT_LOW_LEFT] = 1'b1;
      end else if (pend_ff[SLOT_LOW_HERE]) begin
         sel[SLOT_LOW_HERE] = 1'b1;
      end else begin
         // nothing pending
         sel = '0;
      end
   end

   always_comb begin
      row_lower  = sel[SLOT_LOW_LEFT] || sel[SLOT_LOW_HERE];
      col_right  = sel[SLOT_UP_HERE] || sel[SLOT_LOW_HERE];
      // row r-1 below the top row spans three rows; the bottom row two
      use_s3     = !row_lower && !p2_top_ff;
      // column c-1 right of the left edge spans three columns
      three_cols = !col_right && !p2_left_ff;
      row_m1     = p2_row_ff - POS_BITS'(1);
      col_m1     = p2_col_ff - POS_BITS'(1);
      for (int w = 0; w < WIN_COLS; w++) begin
         for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            col_val[w][ch] = use_s3 ? win_s3_ff[w][ch] : S3_BITS'(win_s2_ff[w][ch]);
         end
      end
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
         sum_in[ch] = SUM_BITS'(col_val[0][ch]) + SUM_BITS'(col_val[1][ch])
                    + (three_cols ? SUM_BITS'(col_val[2][ch]) : SUM_BITS'(0));
      end
      tag_in.row  = OUT_POS_BITS'(row_lower ? p2_row_ff : row_m1);
      tag_in.col  = OUT_POS_BITS'(col_right ? p2_col_ff : col_m1);
      tag_in.last = ((pend_ff & ~sel) == '0);
      tag_in.done = sel[SLOT_LOW_HERE];
      priority if (use_s3 && three_cols) begin
         tag_in.div_code = DIV_BY_9;
      end else if (use_s3 || three_cols) begin
         tag_in.div_code = DIV_BY_6;
      end else begin
         tag_in.div_code = DIV_BY_4;
      end
   end

   // ------------------------------------------------------------------
   // stage 3: sums registered ahead of the divider
   // ------------------------------------------------------------------
   assign p3_ready = !p3_valid_ff || div_in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else if (p3_ready) begin
         p3_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (p3_ready && emit) begin
         sum_ff <= sum_in;
         tag_ff <= tag_in;
      end
   end

   // ------------------------------------------------------------------
   // divide by neighbor count, then the output register
   // ------------------------------------------------------------------
   bmf_mean_div #(
      .CHANNEL_BITS (CHANNEL_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p3_valid_ff),
      .in_ready  (div_in_ready),
      .in_sum    (sum_ff),
      .in_tag    (tag_ff),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_mean  (mean),
      .out_tag   (rsp_tag)
   );

   assign rsp_tdata = RSP_BITS'({rsp_tag.col, rsp_tag.row, mean[2], mean[1], mean[0]});
   assign rsp_tlast = rsp_tag.last;
   assign rsp_tuser = rsp_tag.done;

endmodule

FILE: hw/rtl/bmf_line_ram.sv
// bmf_line_ram.sv: one line store, one write and one registered read port
// depends on bmf_pkg for default sizes
module bmf_line_ram
   import bmf_pkg::*;
#(
   parameter int  DEPTH     = MAX_DIM_DEFAULT,
   parameter int  WIDTH     = NUM_CHANNELS * CHANNEL_BITS_DEFAULT,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read-first: a read and a write at the same address return the old entry
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/bmf_mean_div.sv
// bmf_mean_div.sv: divides neighborhood sums by 4, 6 or 9 in two registered stages
// depends on bmf_pkg for the divisor code and the result tag
module bmf_mean_div
   import bmf_pkg::*;
#(
   parameter int  CHANNEL_BITS = CHANNEL_BITS_DEFAULT,
   localparam int SUM_BITS     = CHANNEL_BITS + 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [SUM_BITS-1:0]     in_sum [NUM_CHANNELS],
   input  result_tag_type          in_tag,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [CHANNEL_BITS-1:0] out_mean [NUM_CHANNELS],
   output result_tag_type          out_tag
);

   localparam int SHIFT     = SUM_BITS + 4;
   localparam int MULT_BITS = SHIFT - 1;
   localparam int QUOT_BITS = SUM_BITS - 2;
   localparam int PROD_BITS = SUM_BITS + MULT_BITS;

   // floor reciprocals: the estimate is the quotient or one below it
   localparam logic [MULT_BITS-1:0] RECIP_4 = MULT_BITS'((64'd1 << SHIFT) / 4);
   localparam logic [MULT_BITS-1:0] RECIP_6 = MULT_BITS'((64'd1 << SHIFT) / 6);
   localparam logic [MULT_BITS-1:0] RECIP_9 = MULT_BITS'((64'd1 << SHIFT) / 9);

   logic                    load_q;
   logic                    load_o;
   logic [MULT_BITS-1:0]    recip;
   logic [PROD_BITS-1:0]    prod [NUM_CHANNELS];
   logic                    q_valid_ff;
   logic [QUOT_BITS-1:0]    q_est_ff [NUM_CHANNELS];
   logic [SUM_BITS-1:0]     q_sum_ff [NUM_CHANNELS];
   result_tag_type          q_tag_ff;
   logic [SUM_BITS-1:0]     divisor;
   logic [SUM_BITS-1:0]     times_d [NUM_CHANNELS];
   logic [SUM_BITS-1:0]     rem [NUM_CHANNELS];
   logic [QUOT_BITS-1:0]    quot_fix [NUM_CHANNELS];
   logic [CHANNEL_BITS-1:0] mean_in [NUM_CHANNELS];
   logic                    out_valid_ff;
   logic [CHANNEL_BITS-1:0] mean_ff [NUM_CHANNELS];
   result_tag_type          tag_ff;

   assign load_o   = !out_valid_ff || out_ready;
   assign load_q   = !q_valid_ff || load_o;
   assign in_ready = load_q;

   always_comb begin
      unique case (in_tag.div_code)
         DIV_BY_4: recip = RECIP_4;
         DIV_BY_6: recip = RECIP_6;
         DIV_BY_9: recip = RECIP_9;
         default:  recip = RECIP_4;
      endcase
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
         prod[ch] = PROD_BITS'(in_sum[ch]) * PROD_BITS'(recip);
      end
   end

   // remainder check lifts an estimate that fell one short
   always_comb begin
      unique case (q_tag_ff.div_code)
         DIV_BY_4: divisor = SUM_BITS'(4);
         DIV_BY_6: divisor = SUM_BITS'(6);
         DIV_BY_9: divisor = SUM_BITS'(9);
         default:  divisor = SUM_BITS'(4);
      endcase
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
         unique case (q_tag_ff.div_code)
            DIV_BY_4: times_d[ch] = SUM_BITS'({q_est_ff[ch], 2'b00});
            DIV_BY_6: times_d[ch] = SUM_BITS'({q_est_ff[ch], 2'b00})
                                  + SUM_BITS'({q_est_ff[ch], 1'b0});
            DIV_BY_9: times_d[ch] = SUM_BITS'({q_est_ff[ch], 3'b000})
                                  + SUM_BITS'(q_est_ff[ch]);
            default:  times_d[ch] = SUM_BITS'({q_est_ff[ch], 2'b00});
         endcase
         rem[ch] = q_sum_ff[ch] - times_d[ch];
         if (rem[ch] >= divisor) begin
            quot_fix[ch] = q_est_ff[ch] + QUOT_BITS'(1);
         end else begin
            quot_fix[ch] = q_est_ff[ch];
         end
         mean_in[ch] = CHANNEL_BITS'(quot_fix[ch]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (load_q) begin
            q_valid_ff <= in_valid;
         end
         if (load_o) begin
            out_valid_ff <= q_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_q && in_valid) begin
         for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            q_est_ff[ch] <= prod[ch][SHIFT +: QUOT_BITS];
            q_sum_ff[ch] <= in_sum[ch];
         end
         q_tag_ff <= in_tag;
      end
      if (load_o && q_valid_ff) begin
         for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            mean_ff[ch] <= mean_in[ch];
         end
         tag_ff <= q_tag_ff;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_mean  = mean_ff;
   assign out_tag   = tag_ff;

endmodule

FILE: hw/rtl/bmf_checker.sv
// bmf_checker.sv: port-level checks on the result channel of box_mean_filter_3x3
// depends on bmf_pkg; bound to the top level at the end of this file
module bmf_rsp_checker
   import bmf_pkg::*;
#(
   parameter int  CHANNEL_BITS = CHANNEL_BITS_DEFAULT,
   localparam int RSP_BITS     = ((NUM_CHANNELS * CHANNEL_BITS + 2 * OUT_POS_BITS + 7) / 8) * 8,
   localparam int ROW_LSB      = NUM_CHANNELS * CHANNEL_BITS,
   localparam int COL_LSB      = ROW_LSB + OUT_POS_BITS
) (
   input logic                clock,
   input logic                reset,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [RSP_BITS-1:0] rsp_tdata,
   input logic                rsp_tlast,
   input logic                rsp_tuser
);

   // nothing comes out right after reset
   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // a stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // bottom-right result closes the run of its request
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("frame done without last of run");

   // bottom-right result sits on the diagonal
   a_done_on_diag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         rsp_tdata[ROW_LSB +: OUT_POS_BITS] == rsp_tdata[COL_LSB +: OUT_POS_BITS])
      else $error("frame done off the diagonal");

endmodule

bind box_mean_filter_3x3 bmf_rsp_checker #(.CHANNEL_BITS(CHANNEL_BITS)) u_bmf_checker (.*);
